FILE: sv/ipt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ipt_pkg;

	localparam int PG_BYTES_W   = 17;
	localparam int FRAMES_W     = 5;
	localparam int CFG_DATA_W   = 17;
	localparam int PROC_W       = 16;
	localparam int PAGE_W       = 20;
	localparam int OFFSET_W     = 16;
	localparam int PADDR_W      = 20;
	localparam int FRAME_OUT_W  = 4;
	localparam int STAMP_W      = 32;

	localparam logic [PG_BYTES_W-1:0] PG_BYTES_RST = 17'd4096;
	localparam logic [FRAMES_W-1:0]   FRAMES_RST   = 5'd16;

	typedef enum logic {
		REG_PG_BYTES      = 1'b0,
		REG_FRAMES_IN_USE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [PROC_W-1:0]   proc_id;
		logic [PAGE_W-1:0]   page_number;
		logic [OFFSET_W-1:0] page_offset;
	} in_item_t;

	typedef struct packed {
		logic [PADDR_W-1:0]     physical_address;
		logic                   hit;
		logic [FRAME_OUT_W-1:0] frame_no;
		logic                   evicted;
	} out_item_t;

	typedef struct packed {
		logic [PROC_W-1:0]  proc_id;
		logic [PAGE_W-1:0]  page_number;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic vld;
		logic hit;
		logic evicted;
	} lkp_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} lkp_state_t;

endpackage
`default_nettype wire

FILE: sv/ipt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ipt_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire ipt_pkg::entry_t wdata,
	input  wire logic [AW-1:0]   raddr,
	output ipt_pkg::entry_t      rdata
);

	ipt_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/ipt_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
module ipt_lookup #(
	parameter int NUM_FRAMES = 16,
	parameter int IW         = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          take,
	input  wire logic [ipt_pkg::PROC_W-1:0]    proc_id,
	input  wire logic [ipt_pkg::PAGE_W-1:0]    page_number,
	input  wire logic [ipt_pkg::FRAMES_W-1:0]  frames_in_use,
	output logic                               lkp_busy,
	output ipt_pkg::lkp_res_t                  res,
	output logic [IW-1:0]                      frame
);

	localparam int CNT_W = $clog2(NUM_FRAMES + 1);
	localparam int CMP_W = (CNT_W > ipt_pkg::FRAMES_W) ? CNT_W : ipt_pkg::FRAMES_W;

	ipt_pkg::lkp_state_t state_q, state_nxt;

	logic [ipt_pkg::PROC_W-1:0]  pid_q;
	logic [ipt_pkg::PAGE_W-1:0]  page_q;
	logic [ipt_pkg::STAMP_W-1:0] count_q;
	logic [NUM_FRAMES-1:0]       valid_q;
	logic [IW-1:0]               scan_cnt_q;
	logic [IW-1:0]               idx_s1;
	logic                        iss_s1;

	logic                        hit_q, free_q;
	logic [IW-1:0]               hit_idx_q, free_idx_q, best_idx_q;
	logic [ipt_pkg::STAMP_W-1:0] best_q;

	logic [CMP_W-1:0] fiu_w;
	logic [CNT_W-1:0] n_act;
	logic [IW-1:0]    last_idx;

	logic             rd_en;
	logic             wr_en;
	logic [IW-1:0]    frame_sel;
	logic             evict_sel;
	ipt_pkg::entry_t  wdata;
	ipt_pkg::entry_t  rdata;
	logic             ent_vld, ent_match;

	assign fiu_w = CMP_W'(frames_in_use);

	always_comb begin
		if (fiu_w == '0) begin
			n_act = CNT_W'(1);
		end else if (fiu_w > CMP_W'(NUM_FRAMES)) begin
			n_act = CNT_W'(NUM_FRAMES);
		end else begin
			n_act = CNT_W'(fiu_w);
		end
	end

	assign last_idx = IW'(n_act - CNT_W'(1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ipt_pkg::ST_IDLE: begin
				if (take) state_nxt = ipt_pkg::ST_SCAN;
			end
			ipt_pkg::ST_SCAN: begin
				if (scan_cnt_q == last_idx) state_nxt = ipt_pkg::ST_DRAIN;
			end
			ipt_pkg::ST_DRAIN:  state_nxt = ipt_pkg::ST_COMMIT;
			ipt_pkg::ST_COMMIT: state_nxt = ipt_pkg::ST_IDLE;
			default:            state_nxt = ipt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		lkp_busy = 1'b1;
		case (state_q)
			ipt_pkg::ST_IDLE:   lkp_busy = 1'b0;
			ipt_pkg::ST_SCAN:   rd_en    = 1'b1;
			ipt_pkg::ST_DRAIN:  ;
			ipt_pkg::ST_COMMIT: wr_en    = 1'b1;
			default:            lkp_busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// frame choice: hit, else lowest free, else oldest stamp
	always_comb begin
		evict_sel = 1'b0;
		if (hit_q) begin
			frame_sel = hit_idx_q;
		end else if (free_q) begin
			frame_sel = free_idx_q;
		end else begin
			frame_sel = best_idx_q;
			evict_sel = 1'b1;
		end
	end

	assign wdata.proc_id     = pid_q;
	assign wdata.page_number = page_q;
	assign wdata.stamp       = count_q + ipt_pkg::STAMP_W'(1);

	ipt_ram #(
		.DEPTH (NUM_FRAMES),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (frame_sel),
		.wdata (wdata),
		.raddr (scan_cnt_q),
		.rdata (rdata)
	);

	assign ent_vld   = valid_q[idx_s1];
	assign ent_match = ent_vld && (rdata.proc_id == pid_q) && (rdata.page_number == page_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			count_q    <= '0;
			scan_cnt_q <= '0;
			iss_s1     <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			res        <= '0;
		end else begin
			iss_s1  <= rd_en;
			res.vld <= wr_en;
			if (take && state_q == ipt_pkg::ST_IDLE) begin
				scan_cnt_q <= '0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
			end else if (rd_en) begin
				scan_cnt_q <= scan_cnt_q + IW'(1);
			end
			if (iss_s1) begin
				if (ent_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!ent_vld && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (wr_en) begin
				valid_q[frame_sel] <= 1'b1;
				count_q            <= count_q + ipt_pkg::STAMP_W'(1);
				res.hit            <= hit_q;
				res.evicted        <= evict_sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_cnt_q;
		if (take && state_q == ipt_pkg::ST_IDLE) begin
			pid_q  <= proc_id;
			page_q <= page_number;
		end
		if (iss_s1) begin
			if (ent_match && !hit_q) hit_idx_q <= idx_s1;
			if (!ent_vld && !free_q) free_idx_q <= idx_s1;
			if (idx_s1 == '0 || rdata.stamp < best_q) begin
				best_q     <= rdata.stamp;
				best_idx_q <= idx_s1;
			end
		end
		if (wr_en) frame <= frame_sel;
	end

	a_valid_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(frame_sel)])
		else $error("written frame not marked valid");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> count_q == $past(count_q) + ipt_pkg::STAMP_W'(1))
		else $error("access count did not advance by one");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		res.vld |-> !(res.hit && res.evicted))
		else $error("hit and eviction both set");

	a_evict_within: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !hit_q && !free_q) |-> best_idx_q <= last_idx)
		else $error("victim outside active frames");

endmodule
`default_nettype wire

FILE: sv/inverted_page_table_lru_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Inverted page table, fully associative, LRU replacement.
// Input: pulse start with req (proc_id, page_number, page_offset) while busy
// is low; the item is taken at that edge.
// Output: done is high for one cycle with rsp (physical_address, hit,
// frame_no, evicted). The receiver cannot stall; rsp is valid only with done.
// Config: cfg_we/cfg_idx/cfg_data write the page size (0) or frames_in_use (1);
// the user must write only while busy is low and no result is pending; the block does not enforce this.
// Sequence: the scan reads the N active frames (N = frames_in_use clamped to
// 1..NUM_FRAMES), then drain, commit, vld_s1 and done follow in order.
// The entry RAM is read one entry per cycle during the scan, then the chosen
// entry is written back; busy falls the cycle done rises, so a new item is
// taken only once the last one is done.
// Reset: all frames marked free, access counter zero, page size 4096,
// frames_in_use 16. RAM contents are not cleared.
module inverted_page_table_lru_top #(
	parameter int NUM_FRAMES = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire ipt_pkg::in_item_t               req,
	output logic                                 done,
	output ipt_pkg::out_item_t                   rsp,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_idx,
	input  wire logic [ipt_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int IW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int FX_W  = (IW > ipt_pkg::FRAME_OUT_W) ? IW : ipt_pkg::FRAME_OUT_W;
	localparam int PROD_W = IW + ipt_pkg::PG_BYTES_W;

	logic [ipt_pkg::PG_BYTES_W-1:0]  pg_bytes_q;
	logic [ipt_pkg::FRAMES_W-1:0]    frames_q;
	logic [ipt_pkg::OFFSET_W-1:0]    offset_q;

	logic                            take;
	logic                            lkp_busy;
	ipt_pkg::lkp_res_t               res;
	logic [IW-1:0]                   frame;

	logic                            vld_s1;
	logic [PROD_W-1:0]               prod_s1;
	logic                            hit_s1, evict_s1;
	logic [FX_W-1:0]                 frame_s1;

	assign busy = lkp_busy | res.vld | vld_s1;
	assign take = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_bytes_q <= ipt_pkg::PG_BYTES_RST;
			frames_q   <= ipt_pkg::FRAMES_RST;
		end else if (cfg_we) begin
			case (ipt_pkg::cfg_reg_t'(cfg_idx))
				ipt_pkg::REG_PG_BYTES:      pg_bytes_q <= cfg_data;
				ipt_pkg::REG_FRAMES_IN_USE: frames_q   <= cfg_data[ipt_pkg::FRAMES_W-1:0];
				default: ;
			endcase
		end
	end

	ipt_lookup #(
		.NUM_FRAMES (NUM_FRAMES),
		.IW         (IW)
	) u_lookup (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.proc_id       (req.proc_id),
		.page_number   (req.page_number),
		.frames_in_use (frames_q),
		.lkp_busy      (lkp_busy),
		.res           (res),
		.frame         (frame)
	);

	always_ff @(posedge clk) begin
		if (take) offset_q <= req.page_offset;
		prod_s1  <= PROD_W'(frame) * PROD_W'(pg_bytes_q);
		hit_s1   <= res.hit;
		evict_s1 <= res.evicted;
		frame_s1 <= FX_W'(frame);
		if (vld_s1) begin
			rsp.physical_address <= prod_s1[ipt_pkg::PADDR_W-1:0]
				+ ipt_pkg::PADDR_W'(offset_q);
			rsp.hit      <= hit_s1;
			rsp.frame_no <= frame_s1[ipt_pkg::FRAME_OUT_W-1:0];
			rsp.evicted  <= evict_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= res.vld;
			done   <= vld_s1;
		end
	end

	a_no_take_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(res.vld || vld_s1) |-> !take)
		else $error("item taken while result pending");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s1, 1) && $past(res.vld, 2))
		else $error("done without lookup result");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results back to back");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam int NUM_FRAMES = 16;
	localparam int STALL_LIMIT = 500;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 200;

	typedef struct {
		logic                           is_cfg;
		logic [ipt_pkg::CFG_DATA_W-1:0] ps;
		logic [ipt_pkg::CFG_DATA_W-1:0] fr;
		ipt_pkg::in_item_t              a;
		logic                           typed;
		ipt_pkg::out_item_t             want;
	} step_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic                           busy;
	ipt_pkg::in_item_t              req = '0;
	logic                           done;
	ipt_pkg::out_item_t             rsp;
	logic                           cfg_we = 1'b0;
	logic                           cfg_idx = 1'b0;
	logic [ipt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	inverted_page_table_lru_top #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow copy of the frame table
	logic                            frame_vld [NUM_FRAMES];
	logic [ipt_pkg::PROC_W-1:0]      frame_proc [NUM_FRAMES];
	logic [ipt_pkg::PAGE_W-1:0]      frame_page [NUM_FRAMES];
	logic [ipt_pkg::STAMP_W-1:0]     frame_stamp [NUM_FRAMES];
	logic [ipt_pkg::STAMP_W-1:0]     access_cnt = '0;
	logic [ipt_pkg::PG_BYTES_W-1:0]  pg_bytes = ipt_pkg::PG_BYTES_RST;
	logic [ipt_pkg::FRAMES_W-1:0]    frames_cfg = ipt_pkg::FRAMES_RST;

	ipt_pkg::out_item_t         xlat_q[$];
	ipt_pkg::out_item_t         head;
	step_t                      plan[$];
	logic [ipt_pkg::PROC_W-1:0] pool_pid[$];
	logic [ipt_pkg::PAGE_W-1:0] pool_page[$];
	int                         errors = 0;
	int                         idle_pct = 0;
	int                         idle_cycles = 0;

	function automatic ipt_pkg::out_item_t translate(ipt_pkg::in_item_t a);
		int                 n;
		int                 fr;
		logic               h;
		logic               ev;
		logic               found;
		longint unsigned    pa;
		ipt_pkg::out_item_t r;
		n = (frames_cfg == 0) ? 1 : (frames_cfg > NUM_FRAMES) ? NUM_FRAMES : int'(frames_cfg);
		fr = 0;
		h = 1'b0;
		ev = 1'b0;
		found = 1'b0;
		access_cnt = access_cnt + 32'd1;
		for (int i = 0; i < n && !found; i++) begin
			if (frame_vld[i] && frame_proc[i] == a.proc_id && frame_page[i] == a.page_number) begin
				fr = i;
				h = 1'b1;
				found = 1'b1;
			end
		end
		for (int i = 0; i < n && !found; i++) begin
			if (!frame_vld[i]) begin
				fr = i;
				found = 1'b1;
			end
		end
		if (!found) begin
			fr = 0;
			for (int i = 1; i < n; i++)
				if (frame_stamp[i] < frame_stamp[fr])
					fr = i;
			ev = 1'b1;
		end
		if (!h) begin
			frame_vld[fr] = 1'b1;
			frame_proc[fr] = a.proc_id;
			frame_page[fr] = a.page_number;
		end
		frame_stamp[fr] = access_cnt;
		pa = 64'(fr);
		pa = pa * pg_bytes + a.page_offset;
		r.physical_address = pa[ipt_pkg::PADDR_W-1:0];
		r.hit = h;
		r.frame_no = fr[ipt_pkg::FRAME_OUT_W-1:0];
		r.evicted = ev;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
		end
	endfunction

	function automatic void add_cfg(logic [ipt_pkg::CFG_DATA_W-1:0] ps,
			logic [ipt_pkg::CFG_DATA_W-1:0] fr);
		step_t s;
		s = '{default: '0};
		s.is_cfg = 1'b1;
		s.ps = ps;
		s.fr = fr;
		plan.push_back(s);
	endfunction

	function automatic void add_item(logic [ipt_pkg::PROC_W-1:0] pid,
			logic [ipt_pkg::PAGE_W-1:0] pg, logic [ipt_pkg::OFFSET_W-1:0] off);
		step_t s;
		s = '{default: '0};
		s.a = '{proc_id: pid, page_number: pg, page_offset: off};
		plan.push_back(s);
	endfunction

	function automatic void add_check(logic [ipt_pkg::PROC_W-1:0] pid,
			logic [ipt_pkg::PAGE_W-1:0] pg, logic [ipt_pkg::OFFSET_W-1:0] off,
			logic [ipt_pkg::PADDR_W-1:0] pa, logic h,
			logic [ipt_pkg::FRAME_OUT_W-1:0] fi, logic ev);
		step_t s;
		s = '{default: '0};
		s.a = '{proc_id: pid, page_number: pg, page_offset: off};
		s.typed = 1'b1;
		s.want = '{physical_address: pa, hit: h, frame_no: fi, evicted: ev};
		plan.push_back(s);
	endfunction

	function automatic ipt_pkg::in_item_t pick_item();
		ipt_pkg::in_item_t a;
		int                k;
		a.proc_id = ipt_pkg::PROC_W'($urandom);
		a.page_number = ipt_pkg::PAGE_W'($urandom);
		a.page_offset = ipt_pkg::OFFSET_W'($urandom);
		if (pool_pid.size() > 0 && $urandom_range(0, 99) < 75) begin
			k = int'($urandom_range(0, pool_pid.size() - 1));
			a.proc_id = pool_pid[k];
			a.page_number = pool_page[k];
		end
		return a;
	endfunction

	task automatic set_config(logic [ipt_pkg::CFG_DATA_W-1:0] ps,
			logic [ipt_pkg::CFG_DATA_W-1:0] fr);
		start <= 1'b0;
		while (xlat_q.size() != 0 || busy)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= ipt_pkg::REG_PG_BYTES;
		cfg_data <= ps;
		@(posedge clk);
		pg_bytes = ps[ipt_pkg::PG_BYTES_W-1:0];
		cfg_idx <= ipt_pkg::REG_FRAMES_IN_USE;
		cfg_data <= fr;
		@(posedge clk);
		frames_cfg = fr[ipt_pkg::FRAMES_W-1:0];
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(ipt_pkg::in_item_t a, logic typed, ipt_pkg::out_item_t want);
		ipt_pkg::out_item_t p;
		start <= 1'b1;
		req <= a;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		p = translate(a);
		xlat_q.push_back(typed ? want : p);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			if ($urandom_range(0, 1)) begin
				@(posedge clk);
				while (busy)
					@(posedge clk);
			end
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (xlat_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, actual %h", $time, rsp);
			end else begin
				head = xlat_q.pop_front();
				check_field("physical_address", 32'(head.physical_address),
					32'(rsp.physical_address));
				check_field("hit", 32'(head.hit), 32'(rsp.hit));
				check_field("frame_no", 32'(head.frame_no), 32'(rsp.frame_no));
				check_field("evicted", 32'(head.evicted), 32'(rsp.evicted));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [ipt_pkg::CFG_DATA_W-1:0] ps;
		logic [ipt_pkg::CFG_DATA_W-1:0] fd;
		logic [ipt_pkg::PROC_W-1:0]     pid_a;
		logic [ipt_pkg::PAGE_W-1:0]     page_a;
		int                             pool_n;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			frame_vld[i] = 1'b0;
			frame_proc[i] = '0;
			frame_page[i] = '0;
			frame_stamp[i] = '0;
		end

		add_check(16'h0000, 20'h00000, 16'h0000, 20'h00000, 1'b0, 4'd0, 1'b0);
		add_check(16'hFFFF, 20'hFFFFF, 16'hFFFF, 20'h10FFF, 1'b0, 4'd1, 1'b0);
		add_check(16'h0000, 20'h00000, 16'h0005, 20'h00005, 1'b1, 4'd0, 1'b0);
		add_check(16'hFFFF, 20'hFFFFF, 16'h0000, 20'h01000, 1'b1, 4'd1, 1'b0);
		// zero page size, zero frame count acts as one frame
		add_cfg(17'h00000, 17'd0);
		add_check(16'h0001, 20'h00001, 16'h0007, 20'h00007, 1'b0, 4'd0, 1'b1);
		add_check(16'h0001, 20'h00001, 16'h0009, 20'h00009, 1'b1, 4'd0, 1'b0);
		add_check(16'hFFFF, 20'hFFFFF, 16'h0003, 20'h00003, 1'b0, 4'd0, 1'b1);
		// count above table size clamps; duplicate entry, lowest index wins
		add_cfg(17'h1FFFF, 17'd31);
		add_check(16'hFFFF, 20'hFFFFF, 16'h0001, 20'h00001, 1'b1, 4'd0, 1'b0);
		add_item(16'h0002, 20'h00002, 16'hFFFF);
		add_item(16'hFFFF, 20'h00000, 16'h0000);
		add_item(16'h0000, 20'hFFFFF, 16'h0000);
		// two frames, oldest stamp goes
		add_cfg(17'h10000, 17'd2);
		add_check(16'h0003, 20'h00003, 16'h0010, 20'h10010, 1'b0, 4'd1, 1'b1);
		add_item(16'h0004, 20'h00004, 16'h0000);
		add_cfg(17'h00001, 17'd17);
		add_item(16'h0002, 20'h00002, 16'hFFFF);
		add_item(16'hFFFF, 20'hFFFFF, 16'h0000);

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 30;
		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				set_config(plan[i].ps, plan[i].fr);
			else
				send_item(plan[i].a, plan[i].typed, plan[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin ps = 17'h1FFFF; fd = 17'd16; end
				1: begin ps = 17'h00000; fd = 17'd0; end
				2: begin ps = 17'h00001; fd = 17'd31; end
				3: begin ps = 17'h10000; fd = 17'd1; end
				default: begin
					case ($urandom_range(0, 4))
						0: ps = 17'h1FFFF;
						1: ps = 17'h10000;
						2: ps = 17'h01000;
						default: ps = ipt_pkg::CFG_DATA_W'($urandom);
					endcase
					fd = ipt_pkg::CFG_DATA_W'($urandom);
					if ($urandom_range(0, 3) != 0)
						fd[ipt_pkg::FRAMES_W-1:0] =
							ipt_pkg::FRAMES_W'($urandom_range(1, NUM_FRAMES));
				end
			endcase
			set_config(ps, fd);

			pool_pid.delete();
			pool_page.delete();
			pid_a = ipt_pkg::PROC_W'($urandom);
			page_a = ipt_pkg::PAGE_W'($urandom);
			pool_n = int'($urandom_range(2, 24));
			for (int j = 0; j < pool_n; j++) begin
				case ($urandom_range(0, 2))
					0: begin
						pool_pid.push_back(pid_a);
						pool_page.push_back(ipt_pkg::PAGE_W'($urandom));
					end
					1: begin
						pool_pid.push_back(ipt_pkg::PROC_W'($urandom));
						pool_page.push_back(page_a);
					end
					default: begin
						pool_pid.push_back(ipt_pkg::PROC_W'($urandom));
						pool_page.push_back(ipt_pkg::PAGE_W'($urandom));
					end
				endcase
			end

			if (p >= PHASES - 2)
				idle_pct = 0;
			else
				idle_pct = 25 * int'($urandom_range(0, 2));
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_item(pick_item(), 1'b0, '0);
		end

		start <= 1'b0;
		while (xlat_q.size() != 0)
			@(posedge clk);
		repeat (30)
			@(posedge clk);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: files.f
sv/ipt_pkg.sv
sv/ipt_ram.sv
sv/ipt_lookup.sv
sv/inverted_page_table_lru_top.sv
tb/testbench.sv
